>>> rtl/abd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and coefficient tables of the ADPCM block decoder.
package abd_pkg;

	localparam int MAX_BLOCK_BYTES_DEF = 4096;
	localparam int BB_W = 13;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int HDR_BYTES = 7;
	localparam int BLOCK_MIN = 7;
	localparam int BLOCK_RESET = 256;
	localparam int COEF_LAST = 6;
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int PCM_MIN = -32768;
	localparam int PCM_MAX = 32767;
	localparam int DELTA_FLOOR = 16;
	localparam int ROUND_BIAS = 255;

	localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

	// Header bytes are numbered by their place in the block; everything after is data.
	typedef enum logic [2:0] {
		HB_INDEX,
		HB_DELTA_LO,
		HB_DELTA_HI,
		HB_NEWEST_LO,
		HB_NEWEST_HI,
		HB_OLDER_LO,
		HB_OLDER_HI,
		HB_DATA
	} byte_kind_t;

	typedef struct packed {
		logic [7:0] left_byte;
		logic [7:0] right_byte;
		byte_kind_t kind;
		logic stereo;
		logic block_end;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] pcm;
		logic channel;
		logic last;
		logic block_end;
		logic bad;
	} res_t;

	typedef struct packed {
		logic signed [31:0] delta;
		logic signed [10:0] c1;
		logic signed [9:0] c2;
		logic signed [15:0] newest;
		logic signed [15:0] older;
		logic ierr;
	} chan_t;

	function automatic logic [9:0] adapt_of(input logic [3:0] nib);
		logic [9:0] v;
		v = 10'd230;
		unique case (nib)
			4'd0, 4'd1, 4'd2, 4'd3: v = 10'd230;
			4'd4: v = 10'd307;
			4'd5: v = 10'd409;
			4'd6: v = 10'd512;
			4'd7: v = 10'd614;
			4'd8: v = 10'd768;
			4'd9: v = 10'd614;
			4'd10: v = 10'd512;
			4'd11: v = 10'd409;
			4'd12: v = 10'd307;
			4'd13, 4'd14, 4'd15: v = 10'd230;
		endcase
		return v;
	endfunction

	function automatic logic signed [10:0] coef1_of(input logic [2:0] idx);
		logic signed [10:0] v;
		v = 11'sd0;
		unique case (idx)
			3'd0: v = 11'sd256;
			3'd1: v = 11'sd512;
			3'd2: v = 11'sd0;
			3'd3: v = 11'sd192;
			3'd4: v = 11'sd240;
			3'd5: v = 11'sd460;
			3'd6: v = 11'sd392;
			default: v = 11'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [9:0] coef2_of(input logic [2:0] idx);
		logic signed [9:0] v;
		v = 10'sd0;
		unique case (idx)
			3'd0: v = 10'sd0;
			3'd1: v = -10'sd256;
			3'd2: v = 10'sd0;
			3'd3: v = 10'sd64;
			3'd4: v = 10'sd0;
			3'd5: v = -10'sd208;
			3'd6: v = -10'sd232;
			default: v = 10'sd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/abd_fifo.sv
`timescale 1ns / 1ps
// Small register queue with occupancy count.
module abd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign rdata = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/abd_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, block position tracking and byte classification.
module abd_front #(
	parameter int MAX_BLOCK_BYTES = abd_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [abd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [abd_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	input  logic [7:0]                       left_byte,
	input  logic [7:0]                       right_byte,
	input  logic                             q_full,
	output logic                             in_stall,
	output logic                             push,
	output abd_pkg::cmd_t                    cmd
);

	localparam int PW = $clog2(MAX_BLOCK_BYTES);
	localparam int CW = (PW + 1 > abd_pkg::BB_W) ? PW + 1 : abd_pkg::BB_W;

	logic stereo_q;
	logic [abd_pkg::BB_W-1:0] block_bytes_q;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] bb_ext;
	logic [CW-1:0] size;
	logic [CW-1:0] pos_inc;
	logic end_hit;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	// Out-of-range sizes are pulled back into the supported span.
	assign bb_ext = CW'(block_bytes_q);
	assign size = (bb_ext < CW'(abd_pkg::BLOCK_MIN)) ? CW'(abd_pkg::BLOCK_MIN) :
		((bb_ext > CW'(MAX_BLOCK_BYTES)) ? CW'(MAX_BLOCK_BYTES) : bb_ext);
	assign pos_inc = CW'(pos_q) + CW'(1);
	assign end_hit = (pos_inc >= size);

	always_comb begin
		cmd.left_byte = left_byte;
		cmd.right_byte = right_byte;
		cmd.stereo = stereo_q;
		cmd.block_end = end_hit;
		if (pos_q < PW'(abd_pkg::HDR_BYTES)) begin
			cmd.kind = abd_pkg::byte_kind_t'(pos_q[2:0]);
		end else begin
			cmd.kind = abd_pkg::HB_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
			block_bytes_q <= abd_pkg::BB_W'(abd_pkg::BLOCK_RESET);
			pos_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					abd_pkg::CFG_STEREO_MODE: stereo_q <= cfg_data[0];
					abd_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_data[abd_pkg::BB_W-1:0];
				endcase
			end
			if (push) begin
				pos_q <= end_hit ? '0 : pos_inc[PW-1:0];
			end
		end
	end

endmodule

>>> rtl/abd_back.sv
`timescale 1ns / 1ps
// Back end: channel state, header loading and the two-stage nibble decoder.
module abd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  abd_pkg::cmd_t                    cmd,
	output logic                             cmd_pop,
	input  logic [abd_pkg::OUT_CNT_W-1:0]    out_count,
	output logic                             res_push,
	output abd_pkg::res_t                    res
);

	abd_pkg::chan_t st_q [2];

	logic [1:0] k_q;
	logic hdr_done_q;

	logic is_hdr;
	logic op_last;
	logic op_ch;
	logic op_half;
	logic [7:0] op_byte;
	logic [3:0] op_nib;
	logic signed [3:0] op_sn;
	logic signed [10:0] op_adapt;
	logic dec_busy;
	logic credit_ok;
	logic [abd_pkg::OUT_CNT_W:0] pending;
	logic write_fire;
	logic op_fire;

	logic valid_s1;
	logic dec_s1;
	logic ch_s1;
	logic last_s1;
	logic end_s1;
	logic bad_s1;
	logic signed [15:0] samp_s1;
	logic signed [26:0] p1_s1;
	logic signed [25:0] p2_s1;
	logic signed [35:0] p3_s1;
	logic signed [42:0] p4_s1;

	logic signed [27:0] sum_b;
	logic signed [27:0] sum_adj;
	logic signed [36:0] pred_w;
	logic signed [15:0] pred_b;
	logic signed [42:0] ad_adj;
	logic signed [34:0] dq_b;
	logic signed [31:0] delta_b;

	function automatic abd_pkg::chan_t hdr_apply(input abd_pkg::chan_t cur,
			input abd_pkg::byte_kind_t kind, input logic [7:0] b);
		abd_pkg::chan_t nx;
		logic [7:0] hi;
		nx = cur;
		hi = '0;
		unique case (kind)
			abd_pkg::HB_INDEX: begin
				if (b > 8'(abd_pkg::COEF_LAST)) begin
					nx.ierr = 1'b1;
					nx.c1 = '0;
					nx.c2 = '0;
				end else begin
					nx.ierr = 1'b0;
					nx.c1 = abd_pkg::coef1_of(b[2:0]);
					nx.c2 = abd_pkg::coef2_of(b[2:0]);
				end
			end
			abd_pkg::HB_DELTA_LO: nx.delta = {24'd0, b};
			abd_pkg::HB_DELTA_HI: begin
				hi = cur.delta[15:8] | b;
				nx.delta = {{16{hi[7]}}, hi, cur.delta[7:0]};
			end
			abd_pkg::HB_NEWEST_LO: nx.newest = {8'd0, b};
			abd_pkg::HB_NEWEST_HI: nx.newest = {cur.newest[15:8] | b, cur.newest[7:0]};
			abd_pkg::HB_OLDER_LO: nx.older = {8'd0, b};
			abd_pkg::HB_OLDER_HI: nx.older = {cur.older[15:8] | b, cur.older[7:0]};
			abd_pkg::HB_DATA: nx = cur;
		endcase
		return nx;
	endfunction

	// Operation k walks the results of one byte: in stereo the channels alternate.
	assign is_hdr = (cmd.kind != abd_pkg::HB_DATA);
	assign op_last = cmd.stereo ? (k_q == 2'd3) : (k_q == 2'd1);
	assign op_ch = cmd.stereo & k_q[0];
	assign op_half = cmd.stereo ? k_q[1] : k_q[0];
	assign op_byte = op_ch ? cmd.right_byte : cmd.left_byte;
	assign op_nib = op_half ? op_byte[3:0] : op_byte[7:4];
	assign op_sn = op_nib;
	assign op_adapt = {1'b0, abd_pkg::adapt_of(op_nib)};

	// A decode in stage one has not yet written its channel state back.
	assign dec_busy = valid_s1 && dec_s1;
	assign pending = {1'b0, out_count} + {{abd_pkg::OUT_CNT_W{1'b0}}, valid_s1};
	assign credit_ok = (pending < (abd_pkg::OUT_CNT_W + 1)'(abd_pkg::OUT_DEPTH));

	assign write_fire = cmd_valid && is_hdr && !hdr_done_q && !dec_busy;
	assign op_fire = cmd_valid && (!is_hdr || hdr_done_q) &&
		!(dec_busy && (ch_s1 == op_ch)) && credit_ok;
	assign cmd_pop = (write_fire && (cmd.kind != abd_pkg::HB_OLDER_HI)) ||
		(op_fire && op_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			hdr_done_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op_fire;
			if (op_fire) begin
				if (op_last) begin
					k_q <= '0;
					hdr_done_q <= 1'b0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end else if (write_fire && (cmd.kind == abd_pkg::HB_OLDER_HI)) begin
				hdr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_fire) begin
			dec_s1 <= !is_hdr;
			ch_s1 <= op_ch;
			last_s1 <= op_last;
			end_s1 <= cmd.block_end;
			bad_s1 <= st_q[op_ch].ierr;
			samp_s1 <= op_half ? st_q[op_ch].newest : st_q[op_ch].older;
			p1_s1 <= st_q[op_ch].newest * st_q[op_ch].c1;
			p2_s1 <= st_q[op_ch].older * st_q[op_ch].c2;
			p3_s1 <= op_sn * st_q[op_ch].delta;
			p4_s1 <= st_q[op_ch].delta * op_adapt;
		end
	end

	// Stage two: truncating divisions by 256, clamping and delta adaptation.
	always_comb begin
		sum_b = $signed({p1_s1[26], p1_s1}) + $signed({{2{p2_s1[25]}}, p2_s1});
		sum_adj = sum_b + (sum_b[27] ? 28'(abd_pkg::ROUND_BIAS) : 28'sd0);
		pred_w = $signed({{17{sum_adj[27]}}, sum_adj[27:8]}) + $signed({p3_s1[35], p3_s1});
		if (pred_w < 37'(abd_pkg::PCM_MIN)) begin
			pred_b = 16'(abd_pkg::PCM_MIN);
		end else if (pred_w > 37'(abd_pkg::PCM_MAX)) begin
			pred_b = 16'(abd_pkg::PCM_MAX);
		end else begin
			pred_b = pred_w[15:0];
		end
		ad_adj = p4_s1 + (p4_s1[42] ? 43'(abd_pkg::ROUND_BIAS) : 43'sd0);
		dq_b = ad_adj[42:8];
		if (dq_b < 35'(abd_pkg::DELTA_FLOOR)) begin
			delta_b = 32'(abd_pkg::DELTA_FLOOR);
		end else if (dq_b > 35'sd2147483647) begin
			delta_b = 32'sh7FFFFFFF;
		end else begin
			delta_b = dq_b[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q[0] <= '0;
			st_q[1] <= '0;
		end else if (dec_busy) begin
			st_q[ch_s1].older <= st_q[ch_s1].newest;
			st_q[ch_s1].newest <= pred_b;
			st_q[ch_s1].delta <= delta_b;
		end else if (write_fire) begin
			st_q[0] <= hdr_apply(st_q[0], cmd.kind, cmd.left_byte);
			if (cmd.stereo) begin
				st_q[1] <= hdr_apply(st_q[1], cmd.kind, cmd.right_byte);
			end
		end
	end

	assign res_push = valid_s1;
	assign res.pcm = dec_s1 ? pred_b : samp_s1;
	assign res.channel = ch_s1;
	assign res.last = last_s1;
	assign res.block_end = end_s1;
	assign res.bad = bad_s1;

endmodule

>>> rtl/adpcm_block_decoder.sv
`timescale 1ns / 1ps
// ADPCM block decoder top level: front end, command queue, decoder and result queue.
//
// The block takes one byte per channel each beat and decodes Microsoft-style ADPCM blocks
// of block_bytes bytes per channel, the first seven being the header. The front end
// accepts a beat every cycle while its four-entry command queue has room; the decoder
// behind it sets the sustained rate. A header byte yields nothing, but the last header
// byte also emits the header's stored samples (two mono, four stereo). In a data byte
// the decoder issues one sample per cycle, while the result queue has room, into a
// two-stage multiply and clamp path, and a sample must wait until the previous
// sample of the same channel has written its predictor state back, so in mono the decoder
// idles between samples while in stereo the two channels interleave. Results leave
// through a four-entry queue, so output stalls do not block input until both queues fill.
module adpcm_block_decoder #(
	parameter int MAX_BLOCK_BYTES = abd_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [abd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [abd_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       left_byte,
	input  logic [7:0]                       right_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [15:0]               pcm_sample,
	output logic                             channel_id,
	output logic                             last_of_run,
	output logic                             block_end,
	output logic                             bad_header
);

	abd_pkg::cmd_t front_cmd;
	abd_pkg::cmd_t head_cmd;
	abd_pkg::res_t back_res;
	abd_pkg::res_t out_res;
	logic front_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic res_push;
	logic res_empty;
	logic [abd_pkg::OUT_CNT_W-1:0] res_count;

	abd_front #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.left_byte(left_byte),
		.right_byte(right_byte),
		.q_full(cmd_full),
		.in_stall(in_stall),
		.push(front_push),
		.cmd(front_cmd)
	);

	abd_fifo #(
		.WIDTH($bits(abd_pkg::cmd_t)),
		.DEPTH(abd_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_push),
		.wdata(front_cmd),
		.pop(cmd_pop),
		.rdata(head_cmd),
		.empty(cmd_empty),
		.full(cmd_full),
		.count()
	);

	abd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!cmd_empty),
		.cmd(head_cmd),
		.cmd_pop(cmd_pop),
		.out_count(res_count),
		.res_push(res_push),
		.res(back_res)
	);

	abd_fifo #(
		.WIDTH($bits(abd_pkg::res_t)),
		.DEPTH(abd_pkg::OUT_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(back_res),
		.pop(out_valid && !out_stall),
		.rdata(out_res),
		.empty(res_empty),
		.full(),
		.count(res_count)
	);

	// The decoder only issues a sample when the result queue has room for it.
	assign out_valid = !res_empty;
	assign pcm_sample = out_res.pcm;
	assign channel_id = out_res.channel;
	assign last_of_run = out_res.last;
	assign block_end = out_res.block_end;
	assign bad_header = out_res.bad;

endmodule
